@@ hw/rtl/kce_pkg.sv @@
// ----------------------------------------------------------------------------
// kce_pkg
// Shared widths, codes, sequencer states and status types of the
// k-combination enumerator.
// ----------------------------------------------------------------------------
package kce_pkg;

	localparam int IDX_W    = 6;
	localparam int OUT_IDX  = 8;
	localparam int N_W      = 7;
	localparam int K_W      = 4;
	localparam int CNT_W    = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	localparam logic [CNT_W-1:0] RESULT_CAP = 7'd64;

	localparam logic CMD_FETCH   = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_N_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_K_SIZE  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic [N_W-1:0] n_total;
		logic [K_W-1:0] k_size;
		logic           ok;
	} cfg_status_t;

endpackage

@@ hw/rtl/kce_if.sv @@
// ----------------------------------------------------------------------------
// kce_if
// Handshake channels of the k-combination enumerator: request, result and
// configuration write.
// ----------------------------------------------------------------------------
interface kce_req_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [kce_pkg::CNT_W-1:0]  max_count;

	modport source (output valid, output cmd, output max_count, input ready);
	modport sink   (input valid, input cmd, input max_count, output ready);
endinterface

interface kce_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [kce_pkg::IDX_W-1:0]  index_0;
	logic [kce_pkg::IDX_W-1:0]  index_1;
	logic [kce_pkg::IDX_W-1:0]  index_2;
	logic [kce_pkg::IDX_W-1:0]  index_3;
	logic [kce_pkg::IDX_W-1:0]  index_4;
	logic [kce_pkg::IDX_W-1:0]  index_5;
	logic [kce_pkg::IDX_W-1:0]  index_6;
	logic [kce_pkg::IDX_W-1:0]  index_7;
	logic                       valid_res;
	logic                       more_left;
	logic                       last;

	modport source (output valid, output index_0, output index_1, output index_2,
		output index_3, output index_4, output index_5, output index_6,
		output index_7, output valid_res, output more_left, output last,
		input ready);
	modport sink   (input valid, input index_0, input index_1, input index_2,
		input index_3, input index_4, input index_5, input index_6,
		input index_7, input valid_res, input more_left, input last,
		output ready);
endinterface

interface kce_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [kce_pkg::CFG_IDX_W-1:0]  index;
	logic [kce_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/k_combination_enumerator.sv @@
// ----------------------------------------------------------------------------
// k_combination_enumerator
// Lists k-element index subsets of 0..n-1 in ascending lexicographic order.
//
// req carries cmd and max_count; rsp carries one combination per transfer;
// cfg writes n_total (index 0) and k_size (index 1); the user must write
// them only while the block is idle, as the block does not enforce it.
// A restart transfer loads 0..k-1 (or clears the flag on a bad pair) and
// gives no result. A fetch gives up to max_count results (64 at most), or
// one result with valid_res low once the list is exhausted. Each result is
// built by a shared compare/increment unit: a scan from position k-1
// downward, one position a cycle, then a refill of the positions to its
// right, one a cycle. req is ready only while idle; a fetch holds the
// block until its last result is transferred. When the receiver stalls,
// the result register holds and the sequencer waits. Reset clears the
// index registers and the flag and sets both configuration registers to 1.
// ----------------------------------------------------------------------------
module k_combination_enumerator #(
	parameter int MAX_K = 8,
	parameter int MAX_N = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	kce_req_if.sink   req,
	kce_rsp_if.source rsp,
	kce_cfg_if.sink   cfg
);

	localparam int NREG = (MAX_K > kce_pkg::OUT_IDX) ? MAX_K : kce_pkg::OUT_IDX;
	localparam int PW   = $clog2(NREG);
	localparam int CW   = PW + 10;

	localparam int IW = kce_pkg::IDX_W;
	localparam int OW = kce_pkg::OUT_IDX;

	kce_pkg::cfg_status_t st;
	kce_pkg::state_t      state_q, state_d;

	logic [IW-1:0]               idx_q [NREG];
	logic                        more_q;
	logic [PW-1:0]               pos_q;
	logic [IW-1:0]               base_q;
	logic [kce_pkg::CNT_W-1:0]   cnt_q, limit_q;
	logic [IW-1:0]               oidx_q [OW];
	logic                        ovres_q, omore_q, olast_q;

	logic                        in_xfer, out_xfer;
	logic                        fetch_go, fetch_empty;
	logic [IW-1:0]               cur, inc;
	logic                        hit, pos_zero, fill_more;
	logic [PW-1:0]               pos_top;
	logic [kce_pkg::CNT_W-1:0]   cnt_next, limit_sat;

	kce_cfg_regs #(.MAX_K(MAX_K), .MAX_N(MAX_N)) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.status (st)
	);

	assign in_xfer  = req.valid && req.ready;
	assign out_xfer = rsp.valid && rsp.ready;

	assign fetch_go    = in_xfer && (req.cmd == kce_pkg::CMD_FETCH) && (req.max_count != '0);
	assign fetch_empty = !(more_q && st.ok);
	assign limit_sat   = (req.max_count > kce_pkg::RESULT_CAP) ? kce_pkg::RESULT_CAP
		: req.max_count;

	// shared step unit
	assign cur       = idx_q[pos_q];
	assign inc       = ((state_q == kce_pkg::ST_FILL) ? base_q : cur) + IW'(1);
	assign hit       = (CW'(cur) + CW'(st.k_size)) < (CW'(st.n_total) + CW'(pos_q));
	assign pos_zero  = (pos_q == '0);
	assign fill_more = (CW'(pos_q) + CW'(1)) < CW'(st.k_size);
	assign pos_top   = PW'(st.k_size - kce_pkg::K_W'(1));
	assign cnt_next  = cnt_q + kce_pkg::CNT_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kce_pkg::ST_IDLE: begin
				if (fetch_go) state_d = fetch_empty ? kce_pkg::ST_SEND : kce_pkg::ST_SCAN;
			end
			kce_pkg::ST_SCAN: begin
				if (hit) state_d = fill_more ? kce_pkg::ST_FILL : kce_pkg::ST_SEND;
				else if (pos_zero) state_d = kce_pkg::ST_SEND;
			end
			kce_pkg::ST_FILL: begin
				if (!fill_more) state_d = kce_pkg::ST_SEND;
			end
			kce_pkg::ST_SEND: begin
				if (out_xfer) state_d = olast_q ? kce_pkg::ST_IDLE : kce_pkg::ST_SCAN;
			end
			default: state_d = kce_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready = (state_q == kce_pkg::ST_IDLE);
		rsp.valid = (state_q == kce_pkg::ST_SEND);
	end

	assign rsp.index_0   = oidx_q[0];
	assign rsp.index_1   = oidx_q[1];
	assign rsp.index_2   = oidx_q[2];
	assign rsp.index_3   = oidx_q[3];
	assign rsp.index_4   = oidx_q[4];
	assign rsp.index_5   = oidx_q[5];
	assign rsp.index_6   = oidx_q[6];
	assign rsp.index_7   = oidx_q[7];
	assign rsp.valid_res = ovres_q;
	assign rsp.more_left = omore_q;
	assign rsp.last      = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kce_pkg::ST_IDLE;
			more_q  <= 1'b0;
			pos_q   <= '0;
			cnt_q   <= '0;
			limit_q <= '0;
			for (int i = 0; i < NREG; i++) idx_q[i] <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				kce_pkg::ST_IDLE: begin
					if (in_xfer && (req.cmd == kce_pkg::CMD_RESTART)) begin
						for (int i = 0; i < NREG; i++)
							idx_q[i] <= (st.ok && (i < int'(st.k_size))) ? IW'(i) : '0;
						more_q <= st.ok;
					end else if (fetch_go) begin
						cnt_q   <= '0;
						limit_q <= limit_sat;
						pos_q   <= pos_top;
						if (fetch_empty) more_q <= 1'b0;
					end
				end
				kce_pkg::ST_SCAN: begin
					if (hit) begin
						idx_q[pos_q] <= inc;
						if (fill_more) pos_q <= pos_q + PW'(1);
					end else if (pos_zero) begin
						more_q <= 1'b0;
					end else begin
						pos_q <= pos_q - PW'(1);
					end
					if ((hit && !fill_more) || (!hit && pos_zero)) cnt_q <= cnt_next;
				end
				kce_pkg::ST_FILL: begin
					idx_q[pos_q] <= inc;
					if (fill_more) pos_q <= pos_q + PW'(1);
					else cnt_q <= cnt_next;
				end
				kce_pkg::ST_SEND: begin
					if (out_xfer && !olast_q) pos_q <= pos_top;
				end
				default: ;
			endcase
		end
	end

	// result register and refill base
	always_ff @(posedge clk) begin
		if ((state_q == kce_pkg::ST_IDLE && fetch_go) ||
			(state_q == kce_pkg::ST_SEND && out_xfer && !olast_q)) begin
			for (int i = 0; i < OW; i++)
				oidx_q[i] <= (!fetch_empty && (i < int'(st.k_size))) ? idx_q[i] : '0;
			ovres_q <= !fetch_empty;
			omore_q <= 1'b0;
			olast_q <= fetch_empty;
		end
		if ((state_q == kce_pkg::ST_SCAN && hit) || state_q == kce_pkg::ST_FILL)
			base_q <= inc;
		if ((state_q == kce_pkg::ST_SCAN && hit && !fill_more) ||
			(state_q == kce_pkg::ST_FILL && !fill_more)) begin
			omore_q <= 1'b1;
			olast_q <= (cnt_next == limit_q);
		end else if (state_q == kce_pkg::ST_SCAN && !hit && pos_zero) begin
			omore_q <= 1'b0;
			olast_q <= 1'b1;
		end
	end

	a_ready_not_sending: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request taken while a result is pending");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.valid_res) |-> (rsp.last && !rsp.more_left))
		else $error("exhausted result not marked last");

	a_no_more_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.more_left) |-> rsp.last)
		else $error("final combination not marked last");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= limit_q)
		else $error("result count beyond request limit");

	a_restart_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && req.cmd == kce_pkg::CMD_RESTART) |=> req.ready)
		else $error("restart left the sequencer busy");

endmodule

@@ hw/rtl/kce_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// kce_cfg_regs
// Configuration registers n_total and k_size with the validity check of
// the pair.
// ----------------------------------------------------------------------------
module kce_cfg_regs #(
	parameter int MAX_K = 8,
	parameter int MAX_N = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	kce_cfg_if.sink                cfg,
	output kce_pkg::cfg_status_t   status
);

	localparam logic [8:0] MaxNW = 9'(MAX_N);
	localparam logic [4:0] MaxKW = 5'(MAX_K);

	logic [kce_pkg::N_W-1:0] n_q;
	logic [kce_pkg::K_W-1:0] k_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= kce_pkg::N_W'(1);
			k_q <= kce_pkg::K_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				kce_pkg::CFG_N_TOTAL: n_q <= cfg.data[kce_pkg::N_W-1:0];
				kce_pkg::CFG_K_SIZE:  k_q <= cfg.data[kce_pkg::K_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		status.n_total = n_q;
		status.k_size  = k_q;
		status.ok      = (k_q != '0) && (5'(k_q) <= MaxKW) &&
			(n_q != '0) && (9'(n_q) <= MaxNW) &&
			(7'(k_q) <= n_q);
	end

endmodule
